// ===== sv/vdl_pkg.sv =====
// Shared types and constants for the velocity deadzone and limiter block.
`timescale 1ns / 1ps

package vdl_pkg;

	// Component and register widths
	localparam int DW = 32;
	localparam int CW = DW - 1;
	localparam int SW = 2 * DW;
	localparam int CFG_IDX_W = 4;

	// Square root pipeline: one result bit per step
	localparam int SQ_PER = 2;
	localparam int SQ_STG = DW / SQ_PER;
	localparam int SQ_REM_W = DW + 3;

	// Divider pipeline: one quotient bit per step
	localparam int DV_PER = 2;
	localparam int DV_STG = DW / DV_PER;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANG = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LIN = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_NOISE_ANG = CFG_IDX_W'(3);

	typedef logic [2:0][DW-1:0] vdl_vec3_t;

	typedef struct packed {
		logic signed [DW-1:0] lin_x;
		logic signed [DW-1:0] lin_y;
		logic signed [DW-1:0] lin_z;
		logic signed [DW-1:0] ang_x;
		logic signed [DW-1:0] ang_y;
		logic signed [DW-1:0] ang_z;
	} vdl_in_t;

	typedef struct packed {
		logic signed [DW-1:0] out_lin_x;
		logic signed [DW-1:0] out_lin_y;
		logic signed [DW-1:0] out_lin_z;
		logic signed [DW-1:0] out_ang_x;
		logic signed [DW-1:0] out_ang_y;
		logic signed [DW-1:0] out_ang_z;
		logic linear_zeroed;
		logic linear_limited;
		logic angular_zeroed;
		logic angular_limited;
	} vdl_out_t;

	// Result of one conditioned vector
	typedef struct packed {
		vdl_vec3_t v;
		logic zeroed;
		logic limited;
	} vdl_vres_t;

	// Per-item side information carried alongside the long arithmetic units
	typedef struct packed {
		logic [2:0] neg;
		vdl_vec3_t mag;
		logic zeroed;
		logic limited;
		logic pass;
	} vdl_sb_t;

endpackage

// ===== sv/vdl_isqrt.sv =====
// Pipelined integer square root, two result bits per stage.
`timescale 1ns / 1ps

module vdl_isqrt (
	input  logic                      clk,
	input  logic                      adv,
	input  logic [vdl_pkg::SW-1:0]    rad,
	output logic [vdl_pkg::DW-1:0]    root
);
	import vdl_pkg::*;

	logic [SQ_REM_W-1:0] rem_q [SQ_STG];
	logic [DW-1:0] root_q [SQ_STG];
	logic [SW-1:0] rad_q [SQ_STG];

	for (genvar g = 0; g < SQ_STG; g++) begin : g_stg
		logic [SQ_REM_W-1:0] rem_in;
		logic [DW-1:0] root_in;
		logic [SW-1:0] rad_in;
		logic [SQ_REM_W-1:0] rem_nx;
		logic [DW-1:0] root_nx;
		logic [SW-1:0] rad_nx;

		if (g == 0) begin : g_first
			assign rem_in = '0;
			assign root_in = '0;
			assign rad_in = rad;
		end else begin : g_next
			assign rem_in = rem_q[g-1];
			assign root_in = root_q[g-1];
			assign rad_in = rad_q[g-1];
		end

		// Digit-by-digit steps: bring down two bits, try root*4+1.
		always_comb begin
			logic [SQ_REM_W-1:0] trial;
			rem_nx = rem_in;
			root_nx = root_in;
			rad_nx = rad_in;
			for (int i = 0; i < SQ_PER; i++) begin
				rem_nx = {rem_nx[SQ_REM_W-3:0], rad_nx[SW-1:SW-2]};
				rad_nx = {rad_nx[SW-3:0], 2'b00};
				trial = SQ_REM_W'({root_nx, 2'b01});
				if (rem_nx >= trial) begin
					rem_nx = rem_nx - trial;
					root_nx = {root_nx[DW-2:0], 1'b1};
				end else begin
					root_nx = {root_nx[DW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[g] <= rem_nx;
				root_q[g] <= root_nx;
				rad_q[g] <= rad_nx;
			end
		end
	end

	assign root = root_q[SQ_STG-1];

endmodule

// ===== sv/vdl_div.sv =====
// Pipelined restoring divider, two quotient bits per stage.
`timescale 1ns / 1ps

module vdl_div (
	input  logic                      clk,
	input  logic                      adv,
	input  logic [vdl_pkg::SW-1:0]    num,
	input  logic [vdl_pkg::DW-1:0]    den,
	output logic [vdl_pkg::DW-1:0]    quo
);
	import vdl_pkg::*;

	// The quotient is known to fit in DW bits, so the upper half starts as remainder.
	logic [DW-1:0] rem_q [DV_STG];
	logic [DW-1:0] low_q [DV_STG];
	logic [DW-1:0] den_q [DV_STG];
	logic [DW-1:0] quo_q [DV_STG];

	for (genvar g = 0; g < DV_STG; g++) begin : g_stg
		logic [DW-1:0] rem_in;
		logic [DW-1:0] low_in;
		logic [DW-1:0] den_in;
		logic [DW-1:0] quo_in;
		logic [DW-1:0] rem_nx;
		logic [DW-1:0] low_nx;
		logic [DW-1:0] quo_nx;

		if (g == 0) begin : g_first
			assign rem_in = num[SW-1:DW];
			assign low_in = num[DW-1:0];
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[g-1];
			assign low_in = low_q[g-1];
			assign den_in = den_q[g-1];
			assign quo_in = quo_q[g-1];
		end

		// Shift in one dividend bit and subtract the divisor where it fits.
		always_comb begin
			logic [DW:0] part;
			logic [DW:0] diff;
			rem_nx = rem_in;
			low_nx = low_in;
			quo_nx = quo_in;
			for (int i = 0; i < DV_PER; i++) begin
				part = {rem_nx, low_nx[DW-1]};
				low_nx = {low_nx[DW-2:0], 1'b0};
				diff = part - {1'b0, den_in};
				if (part >= {1'b0, den_in}) begin
					rem_nx = diff[DW-1:0];
					quo_nx = {quo_nx[DW-2:0], 1'b1};
				end else begin
					rem_nx = part[DW-1:0];
					quo_nx = {quo_nx[DW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[g] <= rem_nx;
				low_q[g] <= low_nx;
				den_q[g] <= den_in;
				quo_q[g] <= quo_nx;
			end
		end
	end

	assign quo = quo_q[DV_STG-1];

endmodule

// ===== sv/vdl_vec.sv =====
// Conditioning pipeline for one 3-vector: deadzone, noise removal and norm limit.
`timescale 1ns / 1ps

module vdl_vec (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      vin_valid,
	input  vdl_pkg::vdl_vec3_t        vin,
	input  logic [vdl_pkg::CW-1:0]    maxv,
	input  logic [vdl_pkg::CW-1:0]    noise,
	output logic                      vout_valid,
	output vdl_pkg::vdl_vres_t        vout
);
	import vdl_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [2:0] neg_s1, neg_s2, neg_s3, neg_s4;
	vdl_vec3_t mag_s1, mag_s2, mag_s3, mag_s4;
	logic [2:0][SW-1:0] sq_s2;
	logic [SW-1:0] dz_s2, dz_s3, dz_s4;
	logic [SW-1:0] lim_s2, lim_s3, lim_s4;
	logic nz_s2, nz_s3, nz_s4;
	logic [SW-1:0] psum_s3, sq2_s3;
	logic [SW-1:0] ssum_s4, ssum_s5;
	vdl_sb_t sb_s5, sb_s6, sb_s7;
	logic [DW-1:0] r_s6, r_s7, t_s6;
	logic [2:0][SW-1:0] prod_s7;
	vdl_vres_t res_s8;

	logic [SQ_STG-1:0] sq_v_q;
	vdl_sb_t sq_sb_q [SQ_STG];
	logic [DV_STG-1:0] dv_v_q;
	vdl_sb_t dv_sb_q [DV_STG];

	logic [DW-1:0] root;
	vdl_vec3_t quo;
	vdl_sb_t sq_sb, dv_sb;

	logic [DW-1:0] n2;
	logic [DW-1:0] nm;
	logic s5_zeroed, s5_limited;

	// Valid bits for the fixed stages and the two long units.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			sq_v_q <= '0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			dv_v_q <= '0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vin_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			sq_v_q <= {sq_v_q[SQ_STG-2:0], v_s5};
			v_s6 <= sq_v_q[SQ_STG-1];
			v_s7 <= v_s6;
			dv_v_q <= {dv_v_q[DV_STG-2:0], v_s7};
			v_s8 <= dv_v_q[DV_STG-1];
		end
	end

	// Stage 1: sign and magnitude of each component.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vin[i][DW-1];
				mag_s1[i] <= vin[i][DW-1] ? (DW'(0) - vin[i]) : vin[i];
			end
		end
	end

	// Stage 2: squares of the components and of the two thresholds.
	assign n2 = {noise, 1'b0};
	assign nm = DW'(noise) + DW'(maxv);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= SW'(mag_s1[i]) * SW'(mag_s1[i]);
			end
			dz_s2 <= SW'(n2) * SW'(n2);
			lim_s2 <= SW'(nm) * SW'(nm);
			nz_s2 <= (noise == '0);
			neg_s2 <= neg_s1;
			mag_s2 <= mag_s1;
		end
	end

	// Stages 3 and 4: sum of squares in two adds.
	always_ff @(posedge clk) begin
		if (adv) begin
			psum_s3 <= sq_s2[0] + sq_s2[1];
			sq2_s3 <= sq_s2[2];
			dz_s3 <= dz_s2;
			lim_s3 <= lim_s2;
			nz_s3 <= nz_s2;
			neg_s3 <= neg_s2;
			mag_s3 <= mag_s2;
			ssum_s4 <= psum_s3 + sq2_s3;
			dz_s4 <= dz_s3;
			lim_s4 <= lim_s3;
			nz_s4 <= nz_s3;
			neg_s4 <= neg_s3;
			mag_s4 <= mag_s3;
		end
	end

	// Stage 5: deadzone and limit decisions on the squared norm.
	assign s5_zeroed = !nz_s4 && (ssum_s4 < dz_s4);
	assign s5_limited = !s5_zeroed && (ssum_s4 > lim_s4);

	always_ff @(posedge clk) begin
		if (adv) begin
			ssum_s5 <= ssum_s4;
			sb_s5.neg <= neg_s4;
			sb_s5.mag <= mag_s4;
			sb_s5.zeroed <= s5_zeroed;
			sb_s5.limited <= s5_limited;
			sb_s5.pass <= (ssum_s4 == '0) || (nz_s4 && !s5_limited);
		end
	end

	// Norm of the vector.
	vdl_isqrt u_isqrt (
		.clk  (clk),
		.adv  (adv),
		.rad  (ssum_s5),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_sb_q[0] <= sb_s5;
			for (int k = 1; k < SQ_STG; k++) begin
				sq_sb_q[k] <= sq_sb_q[k-1];
			end
		end
	end

	assign sq_sb = sq_sb_q[SQ_STG-1];

	// Stage 6: target length. Stage 7: scaled numerators.
	always_ff @(posedge clk) begin
		if (adv) begin
			r_s6 <= root;
			t_s6 <= sq_sb.limited ? DW'(maxv) : (root - DW'(noise));
			sb_s6 <= sq_sb;
			for (int i = 0; i < 3; i++) begin
				prod_s7[i] <= SW'(sb_s6.mag[i]) * SW'(t_s6);
			end
			r_s7 <= r_s6;
			sb_s7 <= sb_s6;
		end
	end

	// Each component scaled by target length over norm.
	for (genvar c = 0; c < 3; c++) begin : g_div
		vdl_div u_div (
			.clk (clk),
			.adv (adv),
			.num (prod_s7[c]),
			.den (r_s7),
			.quo (quo[c])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_sb_q[0] <= sb_s7;
			for (int k = 1; k < DV_STG; k++) begin
				dv_sb_q[k] <= dv_sb_q[k-1];
			end
		end
	end

	assign dv_sb = dv_sb_q[DV_STG-1];

	// Stage 8: pick pass-through or scaled value and restore the sign.
	always_ff @(posedge clk) begin
		logic [DW-1:0] val;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				val = dv_sb.pass ? dv_sb.mag[i] : quo[i];
				if (dv_sb.zeroed) begin
					res_s8.v[i] <= '0;
				end else begin
					res_s8.v[i] <= dv_sb.neg[i] ? (DW'(0) - val) : val;
				end
			end
			res_s8.zeroed <= dv_sb.zeroed;
			res_s8.limited <= dv_sb.limited;
		end
	end

	assign vout_valid = v_s8;
	assign vout = res_s8;

endmodule

// ===== sv/velocity_deadzone_limiter.sv =====
// Velocity deadzone and norm limiter for a linear and an angular Q16.16 3-vector.
// The pipeline has 40 register stages, most of them in the staged square root and dividers.
// Throughput: one item per cycle while no finished result is held by res_stall.
// A stalled result holds the whole pipeline; no item is lost or repeated.
// Reset clears all valid bits and loads both limits to full scale and both noise values to 0.
`timescale 1ns / 1ps

module velocity_deadzone_limiter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  vdl_pkg::vdl_in_t              cmd_data,
	output logic                          res_valid,
	input  logic                          res_stall,
	output vdl_pkg::vdl_out_t             res_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [vdl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vdl_pkg::DW-1:0]        cfg_data
);
	import vdl_pkg::*;

	logic [CW-1:0] max_lin_q, max_ang_q, noise_lin_q, noise_ang_q;
	logic adv;
	logic lin_valid, ang_valid;
	vdl_vec3_t lin_vec, ang_vec;
	vdl_vres_t lin_res, ang_res;

	// Configuration registers; writes beyond the last index are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_lin_q <= '1;
			max_ang_q <= '1;
			noise_lin_q <= '0;
			noise_ang_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAX_LIN: max_lin_q <= cfg_data[CW-1:0];
				CFG_MAX_ANG: max_ang_q <= cfg_data[CW-1:0];
				CFG_NOISE_LIN: noise_lin_q <= cfg_data[CW-1:0];
				CFG_NOISE_ANG: noise_ang_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// The pipeline moves unless a finished item is held at the output.
	assign adv = !res_valid || !res_stall;
	assign cmd_stall = !adv;

	assign lin_vec[0] = cmd_data.lin_x;
	assign lin_vec[1] = cmd_data.lin_y;
	assign lin_vec[2] = cmd_data.lin_z;
	assign ang_vec[0] = cmd_data.ang_x;
	assign ang_vec[1] = cmd_data.ang_y;
	assign ang_vec[2] = cmd_data.ang_z;

	vdl_vec u_lin (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.vin_valid  (cmd_valid),
		.vin        (lin_vec),
		.maxv       (max_lin_q),
		.noise      (noise_lin_q),
		.vout_valid (lin_valid),
		.vout       (lin_res)
	);

	vdl_vec u_ang (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.vin_valid  (cmd_valid),
		.vin        (ang_vec),
		.maxv       (max_ang_q),
		.noise      (noise_ang_q),
		.vout_valid (ang_valid),
		.vout       (ang_res)
	);

	// Both halves run in lockstep, so their valid bits agree.
	assign res_valid = lin_valid && ang_valid;

	assign res_data.out_lin_x = lin_res.v[0];
	assign res_data.out_lin_y = lin_res.v[1];
	assign res_data.out_lin_z = lin_res.v[2];
	assign res_data.out_ang_x = ang_res.v[0];
	assign res_data.out_ang_y = ang_res.v[1];
	assign res_data.out_ang_z = ang_res.v[2];
	assign res_data.linear_zeroed = lin_res.zeroed;
	assign res_data.linear_limited = lin_res.limited;
	assign res_data.angular_zeroed = ang_res.zeroed;
	assign res_data.angular_limited = ang_res.limited;

endmodule
